@@ hw/rtl/ad_report_filter_name_extract_macros.svh @@
// Assertion macros for the advertising report filter.
// Used by modules that carry concurrent checks; expects clk and arst_n in scope.
`ifndef AD_REPORT_FILTER_NAME_EXTRACT_MACROS_SVH
`define AD_REPORT_FILTER_NAME_EXTRACT_MACROS_SVH

// same-cycle implication
`define ARFNE_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ARFNE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/arfne_pkg.sv @@
// Shared types and constants of the advertising report filter.
// No dependencies.
package arfne_pkg;

	// wide enough for any name capacity up to 63
	localparam int NCNT_W = 6;

	localparam logic [7:0] AD_FLAGS      = 8'h01;
	localparam logic [7:0] AD_NAME_SHORT = 8'h08;
	localparam logic [7:0] AD_NAME_FULL  = 8'h09;

	localparam logic [1:0] MODE_ALL     = 2'd0;
	localparam logic [1:0] MODE_LIMITED = 2'd1;
	localparam logic [1:0] MODE_GENERAL = 2'd2;

	typedef enum logic [3:0] {
		NS_SEARCH  = 4'b0001,
		NS_COLLECT = 4'b0010,
		NS_FOUND   = 4'b0100,
		NS_FAILED  = 4'b1000
	} name_st_t;

	typedef enum logic [1:0] {
		BK_IDLE  = 2'b01,
		BK_BYTES = 2'b10
	} back_st_t;

	typedef struct packed {
		logic              accepted;
		logic              name_known;
		logic [NCNT_W-1:0] nbytes;
	} verdict_t;

	typedef struct packed {
		logic              en;
		logic              bank;
		logic [NCNT_W-1:0] idx;
		logic [7:0]        data;
	} name_wr_t;

endpackage

@@ hw/rtl/ad_report_filter_name_extract.sv @@
// A verdict is queued with the report's last byte, then popped from the queue into the output register.
// Throughput: one report byte per cycle while fewer than two reports wait at the output;
// the output sends one result per cycle while out_stall is low, and a report with n name
// bytes sends n+1 results. The two-bank name store sets the limit of two waiting reports.
// Reset (arst_n low, asynchronous) clears the parser, the queue, the output valid and
// sets the filter mode to MODE_ALL; the name store is not cleared and needs no pass after reset.
module ad_report_filter_name_extract #(
	parameter int NAME_CAPACITY = 29
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic [7:0] report_length,
	input  logic       is_last,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_data,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       is_verdict,
	output logic       accepted,
	output logic       name_known,
	output logic [4:0] name_length,
	output logic [7:0] name_byte,
	output logic       last_of_run
);

	logic                push, q_valid, q_pop, bank_free;
	arfne_pkg::verdict_t verdict, q_head;
	arfne_pkg::name_wr_t name_wr;

	arfne_front #(
		.NAME_CAPACITY(NAME_CAPACITY)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.report_length(report_length),
		.is_last      (is_last),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.push         (push),
		.verdict      (verdict),
		.name_wr      (name_wr),
		.bank_free    (bank_free)
	);

	arfne_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   (verdict),
		.pop   (q_pop),
		.valid (q_valid),
		.head  (q_head)
	);

	arfne_back #(
		.NAME_CAPACITY(NAME_CAPACITY)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.name_wr    (name_wr),
		.q_valid    (q_valid),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.bank_free  (bank_free),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.is_verdict (is_verdict),
		.accepted   (accepted),
		.name_known (name_known),
		.name_length(name_length),
		.name_byte  (name_byte),
		.last_of_run(last_of_run)
	);

endmodule

@@ hw/rtl/arfne_front.sv @@
// Front end: walks the length-type-value fields of a report one byte per cycle unless
// stalled, writes name bytes to the back end's store, queues a verdict. Uses arfne_pkg.
module arfne_front #(
	parameter int NAME_CAPACITY = 29
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [7:0]             data_byte,
	input  logic [7:0]             report_length,
	input  logic                   is_last,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [1:0]             cfg_data,
	output logic                   push,
	output arfne_pkg::verdict_t    verdict,
	output arfne_pkg::name_wr_t    name_wr,
	input  logic                   bank_free
);

	localparam int CW = $clog2(NAME_CAPACITY + 1);
	localparam int NW = arfne_pkg::NCNT_W;

	logic [1:0]          mode_q;
	logic [1:0]          busy_q;
	logic                wr_bank_q;
	logic [7:0]          pos_q;
	logic [8:0]          nfs_q, nfs_n;
	logic [7:0]          flen_q, flen_n;
	logic [7:0]          ftype_q, ftype_n;
	logic                stop_q, stop_n;
	logic                flags_q, flags_n;
	logic [7:0]          fval_q, fval_n;
	arfne_pkg::name_st_t ns_q, ns_n;
	logic [CW-1:0]       cnt_q, cnt_n;

	logic       accept;
	logic       active;
	logic [8:0] p9, len9, sum9, rel9, nl9;
	logic       acc, known;

	assign cfg_ready = 1'b1;
	assign in_stall  = (busy_q == 2'd2);
	assign accept    = in_valid && !in_stall;
	assign push      = accept && is_last;

	assign p9   = {1'b0, pos_q};
	assign len9 = {1'b0, report_length};
	assign sum9 = p9 + {1'b0, data_byte};
	// offset of this byte inside the current field: 1 is the type byte
	assign rel9 = p9 + {1'b0, flen_q} + 9'd1 - nfs_q;
	assign nl9  = {1'b0, flen_q} - 9'd1;

	always_comb begin
		nfs_n   = nfs_q;
		flen_n  = flen_q;
		ftype_n = ftype_q;
		stop_n  = stop_q;
		flags_n = flags_q;
		fval_n  = fval_q;
		ns_n    = ns_q;
		cnt_n   = cnt_q;
		name_wr = '0;
		name_wr.bank = wr_bank_q;
		name_wr.idx  = NW'(cnt_q);
		name_wr.data = data_byte;
		active = (report_length != 8'd0) && !stop_q && (pos_q < report_length);
		if (active) begin
			if (p9 == nfs_q) begin
				if (data_byte == 8'd0 || sum9 >= len9) begin
					stop_n = 1'b1;
				end else begin
					flen_n = data_byte;
					nfs_n  = sum9 + 9'd1;
				end
			end else if (rel9 == 9'd1) begin
				ftype_n = data_byte;
				if (data_byte == arfne_pkg::AD_FLAGS && !flags_q && flen_q == 8'd1) begin
					flags_n = 1'b1;
					fval_n  = 8'd0;
				end
				if ((data_byte inside {arfne_pkg::AD_NAME_SHORT, arfne_pkg::AD_NAME_FULL})
						&& ns_q == arfne_pkg::NS_SEARCH) begin
					cnt_n = '0;
					if (nl9 > 9'(NAME_CAPACITY))
						ns_n = arfne_pkg::NS_FAILED;
					else if (nl9 == 9'd0)
						ns_n = arfne_pkg::NS_FOUND;
					else
						ns_n = arfne_pkg::NS_COLLECT;
				end
			end else begin
				if (ftype_q == arfne_pkg::AD_FLAGS && rel9 == 9'd2 && !flags_q) begin
					flags_n = 1'b1;
					fval_n  = data_byte;
				end
				if (ns_q == arfne_pkg::NS_COLLECT
						&& (ftype_q inside {arfne_pkg::AD_NAME_SHORT, arfne_pkg::AD_NAME_FULL})) begin
					name_wr.en = accept && (cnt_q < CW'(NAME_CAPACITY));
					cnt_n = cnt_q + 1'b1;
					if (9'(cnt_q) + 9'd1 >= nl9)
						ns_n = arfne_pkg::NS_FOUND;
				end
			end
		end
	end

	always_comb begin
		case (mode_q)
			arfne_pkg::MODE_ALL:     acc = 1'b1;
			arfne_pkg::MODE_LIMITED: acc = flags_n && fval_n[0];
			arfne_pkg::MODE_GENERAL: acc = flags_n && (fval_n[1:0] != 2'b00);
			default:                 acc = 1'b0;
		endcase
		known = acc && (ns_n == arfne_pkg::NS_FOUND);
		verdict.accepted   = acc;
		verdict.name_known = known;
		verdict.nbytes     = known ? NW'(cnt_n) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= arfne_pkg::MODE_ALL;
		end else if (cfg_valid) begin
			mode_q <= cfg_data;
		end
	end

	// banks held by verdicts that are queued or still being sent out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 2'd0;
		end else begin
			case ({push, bank_free})
				2'b10:   busy_q <= busy_q + 2'd1;
				2'b01:   busy_q <= busy_q - 2'd1;
				default: busy_q <= busy_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_bank_q <= 1'b0;
			pos_q     <= 8'd0;
			nfs_q     <= 9'd0;
			flen_q    <= 8'd0;
			ftype_q   <= 8'd0;
			stop_q    <= 1'b0;
			flags_q   <= 1'b0;
			fval_q    <= 8'd0;
			ns_q      <= arfne_pkg::NS_SEARCH;
			cnt_q     <= '0;
		end else if (accept) begin
			if (is_last) begin
				wr_bank_q <= !wr_bank_q;
				pos_q     <= 8'd0;
				nfs_q     <= 9'd0;
				flen_q    <= 8'd0;
				ftype_q   <= 8'd0;
				stop_q    <= 1'b0;
				flags_q   <= 1'b0;
				fval_q    <= 8'd0;
				ns_q      <= arfne_pkg::NS_SEARCH;
				cnt_q     <= '0;
			end else begin
				pos_q   <= (pos_q != 8'hFF) ? pos_q + 8'd1 : pos_q;
				nfs_q   <= nfs_n;
				flen_q  <= flen_n;
				ftype_q <= ftype_n;
				stop_q  <= stop_n;
				flags_q <= flags_n;
				fval_q  <= fval_n;
				ns_q    <= ns_n;
				cnt_q   <= cnt_n;
			end
		end
	end

endmodule

@@ hw/rtl/arfne_queue.sv @@
// Two-entry verdict queue between the front and back ends.
// Uses arfne_pkg.
module arfne_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  arfne_pkg::verdict_t din,
	input  logic                pop,
	output logic                valid,
	output arfne_pkg::verdict_t head
);

	arfne_pkg::verdict_t ent_q [2];
	logic                wr_ptr_q, rd_ptr_q;
	logic [1:0]          cnt_q;

	assign valid = (cnt_q != 2'd0);
	assign head  = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_ptr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ hw/rtl/arfne_back.sv @@
// Back end: holds the two-bank name store and sends each verdict followed by
// its name bytes through the output register. Uses arfne_pkg and the macro header.
`include "ad_report_filter_name_extract_macros.svh"

module arfne_back #(
	parameter int NAME_CAPACITY = 29
) (
	input  logic                clk,
	input  logic                arst_n,
	input  arfne_pkg::name_wr_t name_wr,
	input  logic                q_valid,
	input  arfne_pkg::verdict_t q_head,
	output logic                q_pop,
	output logic                bank_free,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                is_verdict,
	output logic                accepted,
	output logic                name_known,
	output logic [4:0]          name_length,
	output logic [7:0]          name_byte,
	output logic                last_of_run
);

	localparam int CW = $clog2(NAME_CAPACITY + 1);
	localparam int AW = CW + 1;

	logic [7:0] mem [2**AW];
	logic [7:0] rd_data_q;

	arfne_pkg::back_st_t st_q;
	logic                bank_q;
	logic [CW-1:0]       k_q, n_q;
	logic                out_valid_q, is_verdict_q, accepted_q, name_known_q, last_q;
	logic [4:0]          name_length_q;

	logic load, k_last, rd_en, head_empty;

	assign load       = !out_valid_q || !out_stall;
	assign k_last     = ({1'b0, k_q} + 1'b1) == {1'b0, n_q};
	assign head_empty = (q_head.nbytes == '0);
	assign rd_en      = load && (st_q == arfne_pkg::BK_BYTES);
	assign q_pop      = load && (st_q == arfne_pkg::BK_IDLE) && q_valid;
	assign bank_free  = (rd_en && k_last) || (q_pop && head_empty);

	assign out_valid   = out_valid_q;
	assign is_verdict  = is_verdict_q;
	assign accepted    = accepted_q;
	assign name_known  = name_known_q;
	assign name_length = name_length_q;
	assign name_byte   = is_verdict_q ? 8'd0 : rd_data_q;
	assign last_of_run = last_q;

	always_ff @(posedge clk) begin
		if (name_wr.en)
			mem[{name_wr.bank, name_wr.idx[CW-1:0]}] <= name_wr.data;
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data_q <= mem[{bank_q, k_q}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= arfne_pkg::BK_IDLE;
			bank_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			case (st_q)
				arfne_pkg::BK_BYTES: begin
					out_valid_q <= 1'b1;
					if (k_last) begin
						st_q   <= arfne_pkg::BK_IDLE;
						bank_q <= !bank_q;
					end
				end
				arfne_pkg::BK_IDLE: begin
					out_valid_q <= q_valid;
					if (q_valid) begin
						if (head_empty)
							bank_q <= !bank_q;
						else
							st_q <= arfne_pkg::BK_BYTES;
					end
				end
				default: begin
					st_q        <= arfne_pkg::BK_IDLE;
					out_valid_q <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			is_verdict_q  <= 1'b0;
			accepted_q    <= 1'b1;
			name_known_q  <= 1'b1;
			last_q        <= k_last;
			k_q           <= k_q + 1'b1;
		end else if (q_pop) begin
			is_verdict_q  <= 1'b1;
			accepted_q    <= q_head.accepted;
			name_known_q  <= q_head.name_known;
			name_length_q <= q_head.nbytes[4:0];
			last_q        <= head_empty;
			k_q           <= '0;
			n_q           <= q_head.nbytes[CW-1:0];
		end
	end

	`ARFNE_ASSERT_SAME(a_idx_in_range, st_q == arfne_pkg::BK_BYTES, k_q < n_q, "name index past length")
	`ARFNE_ASSERT_NEXT(a_verdict_then_bytes, q_pop && !head_empty, st_q == arfne_pkg::BK_BYTES, "name bytes not started after verdict")
	`ARFNE_ASSERT_NEXT(a_idle_drains, load && st_q == arfne_pkg::BK_IDLE && !q_valid, !out_valid_q, "result shown with empty queue")

endmodule
